[rtl/multicore_job_scheduler_core_macros.svh]
// Assertion macros shared by the checker files of the job scheduler.
// Depends on nothing; included by the checker by its bare file name.
`ifndef MULTICORE_JOB_SCHEDULER_CORE_MACROS_SVH
`define MULTICORE_JOB_SCHEDULER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MJS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scheduler assertion failed");

// Next-cycle implication, disabled during reset.
`define MJS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scheduler assertion failed");

`endif

[rtl/mjs_pkg.sv]
// Types, codes and the ordering function of the multicore job scheduler.
// Depends on nothing; used by the scheduler top level.
package mjs_pkg;

    typedef struct packed {
        logic [31:0] arrival;
        logic [15:0] left;
        logic [7:0]  id;
        logic [7:0]  prio;
    } job_rec_t;

    localparam logic [2:0] SCH_FCFS = 3'd0;
    localparam logic [2:0] SCH_SJF  = 3'd1;
    localparam logic [2:0] SCH_PSJF = 3'd2;
    localparam logic [2:0] SCH_PRI  = 3'd3;
    localparam logic [2:0] SCH_PPRI = 3'd4;
    localparam logic [2:0] SCH_RR   = 3'd5;

    localparam logic [1:0] OP_NEW    = 2'd0;
    localparam logic [1:0] OP_FINISH = 2'd1;
    localparam logic [1:0] OP_EXPIRE = 2'd2;

    localparam logic [7:0] CFG_SCHEME    = 8'd0;
    localparam logic [7:0] CFG_NUM_CORES = 8'd1;

    // True if a strictly precedes b under the given scheme.
    function automatic logic better(input logic [2:0] sch, input job_rec_t a,
                                    input job_rec_t b);
        logic r;
        r = 1'b0;
        case (sch)
            SCH_SJF, SCH_PSJF:
            begin
                if (a.left != b.left) r = (a.left < b.left);
                else r = (a.arrival < b.arrival);
            end
            SCH_PRI, SCH_PPRI:
            begin
                if (a.prio != b.prio) r = (a.prio < b.prio);
                else r = (a.arrival < b.arrival);
            end
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

[rtl/multicore_job_scheduler_core.sv]
// Multicore job scheduler: per-core running records, sorted wait queue in memory; uses mjs_pkg.
// Steps: an arrival scans the active cores, charging busy ones, then seats the job on a free
// core; else a preemptive scheme scans for the worst running job, and a queue insertion searches
// the sorted queue and shifts later entries. Throughput: one event at a time,
// the next accepted on the cycle after the result is registered unless a stalled result waits.
// Reset clears busy flags, queue count and control; records and queue stay unset.
module multicore_job_scheduler_core #(
    parameter int CORES       = 8,
    parameter int QUEUE_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // job_id[7:0], now[39:8], run_length[55:40], job_priority[63:56], core_index[66:64]
    input  logic [71:0] s_tdata,
    // opcode[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // placed_core[3:0], placed_job[12:4], queue_overflow[13]
    output logic [15:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam int CIW = (CORES > 1) ? $clog2(CORES) : 1;
    localparam int QW  = $clog2(QUEUE_DEPTH);
    localparam int CW  = QW + 1;
    localparam int SW  = CW + 1;

    localparam logic [4:0] S_IDLE      = 5'd0;
    localparam logic [4:0] S_ACC       = 5'd1;
    localparam logic [4:0] S_DECIDE    = 5'd2;
    localparam logic [4:0] S_WORST     = 5'd3;
    localparam logic [4:0] S_PRECMP    = 5'd4;
    localparam logic [4:0] S_INS_START = 5'd5;
    localparam logic [4:0] S_INS_RD    = 5'd6;
    localparam logic [4:0] S_INS_CMP   = 5'd7;
    localparam logic [4:0] S_SHF_RD    = 5'd8;
    localparam logic [4:0] S_SHF_WR    = 5'd9;
    localparam logic [4:0] S_INS_WR    = 5'd10;
    localparam logic [4:0] S_POP_START = 5'd11;
    localparam logic [4:0] S_POP_USE   = 5'd12;
    localparam logic [4:0] S_EXP_ACC   = 5'd13;
    localparam logic [4:0] S_EXP_CHK   = 5'd14;
    localparam logic [4:0] S_EXP_CMP   = 5'd15;
    localparam logic [4:0] S_OUT       = 5'd16;

    function automatic logic [QW-1:0] phys(input logic [QW-1:0] h, input logic [CW-1:0] i);
        logic [SW-1:0] s;
        s = SW'(h) + SW'(i);
        if (s >= SW'(QUEUE_DEPTH)) s = s - SW'(QUEUE_DEPTH);
        return s[QW-1:0];
    endfunction

    logic [4:0]        state_reg, state_next;
    logic [31:0]       now_reg, now_next;
    mjs_pkg::job_rec_t job_reg, job_next;
    logic [2:0]        c_reg, c_next;
    logic [CIW-1:0]    idx_reg, idx_next;
    logic              found_reg, found_next;
    logic [CIW-1:0]    free_reg, free_next;
    mjs_pkg::job_rec_t wrec_reg, wrec_next;
    logic [CIW-1:0]    widx_reg, widx_next;
    mjs_pkg::job_rec_t ins_reg, ins_next;
    logic [CW-1:0]     pos_reg, pos_next;
    logic [CW-1:0]     scan_reg, scan_next;
    logic [CW-1:0]     sh_reg, sh_next;
    logic              aft_pop_reg, aft_pop_next;
    logic [3:0]        pc_reg, pc_next;
    logic [8:0]        pj_reg, pj_next;
    logic              ov_reg, ov_next;
    logic              out_valid_reg, out_valid_next;
    logic [15:0]       out_data_reg, out_data_next;
    logic [2:0]        scheme_reg, scheme_next;
    logic [3:0]        num_reg, num_next;
    logic [QW-1:0]     head_reg, head_next;
    logic [CW-1:0]     count_reg, count_next;

    logic              busy_reg [CORES];
    mjs_pkg::job_rec_t rec_reg  [CORES];
    logic [31:0]       last_reg [CORES];
    mjs_pkg::job_rec_t mem [QUEUE_DEPTH];
    mjs_pkg::job_rec_t rdata_reg;

    logic              core_we, busy_we, busy_val, mem_we;
    logic [CIW-1:0]    core_wr_idx, busy_idx, core_rd_idx;
    mjs_pkg::job_rec_t core_wr_rec, mem_wdata, cmp_a, cmp_b, rd_rec, acc_rec;
    logic [QW-1:0]     mem_waddr, mem_raddr;
    logic [31:0]       rd_last, elapsed;
    logic              cmp_res, last_core, c_ok, q_full;
    logic [5:0]        n_ext;
    logic [2:0]        in_c;
    logic [CIW-1:0]    c_idx, in_c_idx;
    mjs_pkg::job_rec_t in_job;
    logic [QW-1:0]     head_inc;

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    assign in_c           = s_tdata[66:64];
    assign in_c_idx       = CIW'(in_c);
    assign c_idx          = CIW'(c_reg);
    assign in_job.arrival = s_tdata[39:8];
    assign in_job.left    = s_tdata[55:40];
    assign in_job.id      = s_tdata[7:0];
    assign in_job.prio    = s_tdata[63:56];

    assign n_ext = (num_reg == 4'd0) ? 6'd1 :
                   ({2'b00, num_reg} > 6'(CORES)) ? 6'(CORES) : {2'b00, num_reg};
    assign last_core = (6'(idx_reg) == n_ext - 6'd1);
    assign c_ok      = ({3'b000, in_c} < n_ext);
    assign q_full    = (count_reg >= CW'(QUEUE_DEPTH));
    assign head_inc  = (head_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + QW'(1);

    assign rd_rec  = rec_reg[core_rd_idx];
    assign rd_last = last_reg[core_rd_idx];
    assign elapsed = now_reg - rd_last;
    always_comb
    begin
        acc_rec = rd_rec;
        if (elapsed >= {16'd0, rd_rec.left}) acc_rec.left = 16'd0;
        else acc_rec.left = rd_rec.left - elapsed[15:0];
    end

    assign cmp_res = mjs_pkg::better(scheme_reg, cmp_a, cmp_b);

    always_comb
    begin
        state_next     = state_reg;
        now_next       = now_reg;
        job_next       = job_reg;
        c_next         = c_reg;
        idx_next       = idx_reg;
        found_next     = found_reg;
        free_next      = free_reg;
        wrec_next      = wrec_reg;
        widx_next      = widx_reg;
        ins_next       = ins_reg;
        pos_next       = pos_reg;
        scan_next      = scan_reg;
        sh_next        = sh_reg;
        aft_pop_next   = aft_pop_reg;
        pc_next        = pc_reg;
        pj_next        = pj_reg;
        ov_next        = ov_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;
        scheme_next    = scheme_reg;
        num_next       = num_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        core_we        = 1'b0;
        core_wr_idx    = c_idx;
        core_wr_rec    = acc_rec;
        busy_we        = 1'b0;
        busy_idx       = c_idx;
        busy_val       = 1'b1;
        mem_we         = 1'b0;
        mem_waddr      = head_reg;
        mem_wdata      = ins_reg;
        mem_raddr      = head_reg;
        core_rd_idx    = c_idx;
        cmp_a          = ins_reg;
        cmp_b          = rdata_reg;

        if (cfg_valid)
        begin
            if (cfg_index == mjs_pkg::CFG_SCHEME) scheme_next = cfg_data[2:0];
            else if (cfg_index == mjs_pkg::CFG_NUM_CORES) num_next = cfg_data[3:0];
        end

        if (out_valid_reg && m_tready) out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    now_next   = s_tdata[39:8];
                    job_next   = in_job;
                    c_next     = in_c;
                    pc_next    = 4'hF;
                    pj_next    = 9'h1FF;
                    ov_next    = 1'b0;
                    idx_next   = '0;
                    found_next = 1'b0;
                    case (s_tuser)
                        mjs_pkg::OP_NEW:    state_next = S_ACC;
                        mjs_pkg::OP_FINISH: state_next = c_ok ? S_POP_START : S_OUT;
                        mjs_pkg::OP_EXPIRE:
                        begin
                            if (!c_ok) state_next = S_OUT;
                            else if (busy_reg[in_c_idx]) state_next = S_EXP_ACC;
                            else state_next = S_POP_START;
                        end
                        default: state_next = S_OUT;
                    endcase
                end
            end
            S_ACC:
            begin
                core_rd_idx = idx_reg;
                if (busy_reg[idx_reg])
                begin
                    core_we     = 1'b1;
                    core_wr_idx = idx_reg;
                end
                else if (!found_reg)
                begin
                    found_next = 1'b1;
                    free_next  = idx_reg;
                end
                if (last_core) state_next = S_DECIDE;
                else idx_next = idx_reg + CIW'(1);
            end
            S_DECIDE:
            begin
                core_rd_idx = '0;
                if (found_reg)
                begin
                    core_we     = 1'b1;
                    core_wr_idx = free_reg;
                    core_wr_rec = job_reg;
                    busy_we     = 1'b1;
                    busy_idx    = free_reg;
                    pc_next     = 4'(free_reg);
                    state_next  = S_OUT;
                end
                else if (scheme_reg == mjs_pkg::SCH_PSJF || scheme_reg == mjs_pkg::SCH_PPRI)
                begin
                    wrec_next  = rd_rec;
                    widx_next  = '0;
                    idx_next   = CIW'(1);
                    state_next = (n_ext == 6'd1) ? S_PRECMP : S_WORST;
                end
                else
                begin
                    ins_next     = job_reg;
                    aft_pop_next = 1'b0;
                    state_next   = S_INS_START;
                end
            end
            S_WORST:
            begin
                core_rd_idx = idx_reg;
                cmp_a       = wrec_reg;
                cmp_b       = rd_rec;
                if (cmp_res)
                begin
                    wrec_next = rd_rec;
                    widx_next = idx_reg;
                end
                if (last_core) state_next = S_PRECMP;
                else idx_next = idx_reg + CIW'(1);
            end
            S_PRECMP:
            begin
                cmp_a        = job_reg;
                cmp_b        = wrec_reg;
                aft_pop_next = 1'b0;
                state_next   = S_INS_START;
                if (cmp_res)
                begin
                    core_we     = 1'b1;
                    core_wr_idx = widx_reg;
                    core_wr_rec = job_reg;
                    pc_next     = 4'(widx_reg);
                    ins_next    = wrec_reg;
                end
                else ins_next = job_reg;
            end
            S_INS_START:
            begin
                if (q_full)
                begin
                    ov_next    = 1'b1;
                    state_next = aft_pop_reg ? S_POP_START : S_OUT;
                end
                else if (count_reg == '0)
                begin
                    pos_next   = '0;
                    state_next = S_INS_WR;
                end
                else
                begin
                    scan_next  = '0;
                    state_next = S_INS_RD;
                end
            end
            S_INS_RD:
            begin
                mem_raddr  = phys(head_reg, scan_reg);
                state_next = S_INS_CMP;
            end
            S_INS_CMP:
            begin
                if (cmp_res)
                begin
                    pos_next   = scan_reg;
                    sh_next    = count_reg - CW'(1);
                    state_next = S_SHF_RD;
                end
                else if (scan_reg == count_reg - CW'(1))
                begin
                    pos_next   = count_reg;
                    state_next = S_INS_WR;
                end
                else
                begin
                    scan_next  = scan_reg + CW'(1);
                    state_next = S_INS_RD;
                end
            end
            S_SHF_RD:
            begin
                mem_raddr  = phys(head_reg, sh_reg);
                state_next = S_SHF_WR;
            end
            S_SHF_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = phys(head_reg, sh_reg + CW'(1));
                mem_wdata = rdata_reg;
                if (sh_reg == pos_reg) state_next = S_INS_WR;
                else
                begin
                    sh_next    = sh_reg - CW'(1);
                    state_next = S_SHF_RD;
                end
            end
            S_INS_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = phys(head_reg, pos_reg);
                mem_wdata  = ins_reg;
                count_next = count_reg + CW'(1);
                state_next = aft_pop_reg ? S_POP_START : S_OUT;
            end
            S_POP_START:
            begin
                if (count_reg == '0)
                begin
                    busy_we    = 1'b1;
                    busy_val   = 1'b0;
                    state_next = S_OUT;
                end
                else state_next = S_POP_USE;
            end
            S_POP_USE:
            begin
                core_we     = 1'b1;
                core_wr_rec = rdata_reg;
                busy_we     = 1'b1;
                pj_next     = {1'b0, rdata_reg.id};
                head_next   = head_inc;
                count_next  = count_reg - CW'(1);
                state_next  = S_OUT;
            end
            S_EXP_ACC:
            begin
                core_we    = 1'b1;
                state_next = S_EXP_CHK;
            end
            S_EXP_CHK:
            begin
                if (q_full) state_next = S_EXP_CMP;
                else
                begin
                    ins_next     = rd_rec;
                    aft_pop_next = 1'b1;
                    state_next   = S_INS_START;
                end
            end
            S_EXP_CMP:
            begin
                cmp_a = rd_rec;
                if (cmp_res)
                begin
                    pj_next    = {1'b0, rd_rec.id};
                    state_next = S_OUT;
                end
                else
                begin
                    ins_next     = rd_rec;
                    core_we      = 1'b1;
                    core_wr_rec  = rdata_reg;
                    pj_next      = {1'b0, rdata_reg.id};
                    head_next    = head_inc;
                    count_next   = count_reg - CW'(1);
                    aft_pop_next = 1'b0;
                    state_next   = S_INS_START;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {2'b00, ov_reg, pj_reg, pc_reg};
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            scheme_reg    <= mjs_pkg::SCH_FCFS;
            num_reg       <= 4'd1;
            head_reg      <= '0;
            count_reg     <= '0;
            found_reg     <= 1'b0;
            aft_pop_reg   <= 1'b0;
            for (int i = 0; i < CORES; i++) busy_reg[i] <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            scheme_reg    <= scheme_next;
            num_reg       <= num_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            found_reg     <= found_next;
            aft_pop_reg   <= aft_pop_next;
            if (busy_we) busy_reg[busy_idx] <= busy_val;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg      <= now_next;
        job_reg      <= job_next;
        c_reg        <= c_next;
        idx_reg      <= idx_next;
        free_reg     <= free_next;
        wrec_reg     <= wrec_next;
        widx_reg     <= widx_next;
        ins_reg      <= ins_next;
        pos_reg      <= pos_next;
        scan_reg     <= scan_next;
        sh_reg       <= sh_next;
        pc_reg       <= pc_next;
        pj_reg       <= pj_next;
        ov_reg       <= ov_next;
        out_data_reg <= out_data_next;
        if (core_we)
        begin
            rec_reg[core_wr_idx]  <= core_wr_rec;
            last_reg[core_wr_idx] <= now_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        rdata_reg <= mem[mem_raddr];
    end

endmodule

[rtl/mjs_checker.sv]
// Port-level checker for the multicore job scheduler, bound to its top level.
// Depends on multicore_job_scheduler_core_macros.svh for the assertion macros.
`include "multicore_job_scheduler_core_macros.svh"

module mjs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // The block works on one transaction at a time.
    `MJS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_tvalid && s_tready, !s_tready)
    // A result waiting for the sink holds its value.
    `MJS_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready,
                     m_tvalid && $stable(m_tdata))
    // A result never reports both a placed core and a placed job.
    `MJS_ASSERT_NOW(a_one_kind, clk, rst_n, m_tvalid,
                    m_tdata[3:0] == 4'hF || m_tdata[12:4] == 9'h1FF)
    // Overflow only comes from an arrival, which reports no placed job.
    `MJS_ASSERT_NOW(a_ovf_arrival, clk, rst_n, m_tvalid && m_tdata[13],
                    m_tdata[12:4] == 9'h1FF)

endmodule

bind multicore_job_scheduler_core mjs_checker u_mjs_checker (.*);

[tb/multicore_job_scheduler_core_test.sv]
// Self-checking testbench for the multicore job scheduler core.
// Depends on mjs_pkg and multicore_job_scheduler_core; a scoreboard class
// predicts each placement from its own copy of the core records and wait queue.
module multicore_job_scheduler_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_UNKNOWN = 2'd3;

    typedef struct packed {
        logic [3:0] placed_core;
        logic [8:0] placed_job;
        logic       overflow;
    } placement_t;

    class placement_board;
        logic [2:0] sch;
        logic [3:0] ncores;
        logic       busy [8];
        mjs_pkg::job_rec_t run_rec [8];
        logic [31:0] last_acc [8];
        mjs_pkg::job_rec_t waitq [$];
        placement_t pending [$];
        int errors;

        function void clear();
            sch = mjs_pkg::SCH_FCFS;
            ncores = 4'd1;
            foreach (busy[i]) busy[i] = 1'b0;
            waitq.delete();
            pending.delete();
            errors = 0;
        endfunction

        function int active();
            if (ncores == 0) return 1;
            if (ncores > 8) return 8;
            return int'(ncores);
        endfunction

        function logic precedes(mjs_pkg::job_rec_t a, mjs_pkg::job_rec_t b);
            if (sch == mjs_pkg::SCH_SJF || sch == mjs_pkg::SCH_PSJF)
                return (a.left != b.left) ? a.left < b.left : a.arrival < b.arrival;
            if (sch == mjs_pkg::SCH_PRI || sch == mjs_pkg::SCH_PPRI)
                return (a.prio != b.prio) ? a.prio < b.prio : a.arrival < b.arrival;
            return 1'b0;
        endfunction

        function logic enqueue(mjs_pkg::job_rec_t j);
            int pos;
            if (waitq.size() >= 64) return 1'b0;
            pos = waitq.size();
            foreach (waitq[i])
            begin
                if (precedes(j, waitq[i]))
                begin
                    pos = i;
                    break;
                end
            end
            waitq.insert(pos, j);
            return 1'b1;
        endfunction

        function void charge(int c, logic [31:0] now);
            logic [31:0] el;
            el = now - last_acc[c];
            if (el >= {16'd0, run_rec[c].left}) run_rec[c].left = 16'd0;
            else run_rec[c].left = run_rec[c].left - el[15:0];
            last_acc[c] = now;
        endfunction

        function void seat(int c, mjs_pkg::job_rec_t j, logic [31:0] now);
            run_rec[c] = j;
            busy[c] = 1'b1;
            last_acc[c] = now;
        endfunction

        function logic [8:0] pull(int c, logic [31:0] now);
            mjs_pkg::job_rec_t h;
            busy[c] = 1'b0;
            if (waitq.size() == 0) return 9'h1FF;
            h = waitq.pop_front();
            seat(c, h, now);
            return {1'b0, h.id};
        endfunction

        function void note_event(logic [1:0] op, logic [71:0] d);
            placement_t r;
            mjs_pkg::job_rec_t j, cur, h;
            logic [31:0] now;
            int c, n, w, found;
            logic done;
            now = d[39:8];
            c = int'(d[66:64]);
            n = active();
            r = '{4'hF, 9'h1FF, 1'b0};
            if (op == mjs_pkg::OP_NEW)
            begin
                j = '{now, d[55:40], d[7:0], d[63:56]};
                for (int i = 0; i < n; i++) if (busy[i]) charge(i, now);
                found = -1;
                for (int i = 0; i < n; i++)
                begin
                    if (!busy[i])
                    begin
                        found = i;
                        break;
                    end
                end
                if (found >= 0)
                begin
                    seat(found, j, now);
                    r.placed_core = 4'(found);
                end
                else
                begin
                    done = 1'b0;
                    if (sch == mjs_pkg::SCH_PSJF || sch == mjs_pkg::SCH_PPRI)
                    begin
                        w = 0;
                        for (int i = 1; i < n; i++)
                            if (precedes(run_rec[w], run_rec[i])) w = i;
                        if (precedes(j, run_rec[w]))
                        begin
                            cur = run_rec[w];
                            seat(w, j, now);
                            r.placed_core = 4'(w);
                            if (!enqueue(cur)) r.overflow = 1'b1;
                            done = 1'b1;
                        end
                    end
                    if (!done && !enqueue(j)) r.overflow = 1'b1;
                end
            end
            else if (op == mjs_pkg::OP_FINISH)
            begin
                if (c < n) r.placed_job = pull(c, now);
            end
            else if (op == mjs_pkg::OP_EXPIRE && c < n)
            begin
                if (!busy[c]) r.placed_job = pull(c, now);
                else
                begin
                    charge(c, now);
                    cur = run_rec[c];
                    if (waitq.size() >= 64 && precedes(cur, waitq[0]))
                        r.placed_job = {1'b0, cur.id};
                    else if (waitq.size() >= 64)
                    begin
                        h = waitq.pop_front();
                        void'(enqueue(cur));
                        seat(c, h, now);
                        r.placed_job = {1'b0, h.id};
                    end
                    else
                    begin
                        void'(enqueue(cur));
                        h = waitq.pop_front();
                        seat(c, h, now);
                        r.placed_job = {1'b0, h.id};
                    end
                end
            end
            pending.push_back(r);
        endfunction

        function void check_result(logic [15:0] t);
            placement_t e;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("unexpected transaction %h", t);
                return;
            end
            e = pending.pop_front();
            if (t[3:0] !== e.placed_core || t[12:4] !== e.placed_job
                || t[13] !== e.overflow)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: core %h/%h job %h/%h ovf %b/%b",
                             e.placed_core, t[3:0], e.placed_job, t[12:4],
                             e.overflow, t[13]);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [71:0] s_tdata = '0;
    logic [1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [7:0] cfg_index = '0;
    logic [7:0] cfg_data = '0;

    placement_board board;
    logic calm = 1'b0;
    logic [31:0] clock_now = 0;
    logic [7:0] id_next = 0;

    multicore_job_scheduler_core dut (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        #60ms;
        $display("TB_ERROR");
        $finish;
    end

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready) board.check_result(m_tdata);

    initial
    begin
        int gap;
        @(posedge clk);
        forever
        begin
            m_tready <= 1'b1;
            @(posedge clk);
            if (!calm && $urandom_range(0, 9) == 0)
            begin
                gap = $urandom_range(1, 17);
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    task automatic write_reg(logic [7:0] idx, logic [7:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == mjs_pkg::CFG_SCHEME) board.sch = val[2:0];
        else if (idx == mjs_pkg::CFG_NUM_CORES) board.ncores = val[3:0];
        @(posedge clk);
    endtask

    task automatic send_event(logic [1:0] op, logic [7:0] id, logic [15:0] len,
                              logic [7:0] pri, logic [2:0] core);
        logic [71:0] d;
        int gap;
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 17);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        clock_now = clock_now + $urandom_range(0, 40);
        if ($urandom_range(0, 30) == 0) clock_now = $urandom;
        d = {5'd0, core, pri, len, clock_now, id};
        s_tdata <= d;
        s_tuser <= op;
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        board.note_event(op, d);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (600) @(posedge clk);
    endtask

    task automatic random_event(int heavy);
        int k;
        logic [1:0] op;
        k = $urandom_range(0, 99);
        op = (k < heavy) ? mjs_pkg::OP_NEW :
             (k < 97) ? (k[0] ? mjs_pkg::OP_FINISH : mjs_pkg::OP_EXPIRE) : OP_UNKNOWN;
        id_next = id_next + 8'd1;
        send_event(op, ($urandom_range(0, 3) == 0) ? 8'($urandom) : id_next,
                   ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 60)),
                   8'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 7)),
                   3'($urandom));
    endtask

    initial
    begin
        board = new();
        board.clear();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(mjs_pkg::CFG_NUM_CORES, 8'd2);
        write_reg(mjs_pkg::CFG_SCHEME, {5'd0, mjs_pkg::SCH_PSJF});
        send_event(mjs_pkg::OP_NEW, 8'd0, 16'hFFFF, 8'hFF, 3'd0);
        send_event(mjs_pkg::OP_NEW, 8'hFF, 16'd0, 8'd0, 3'd7);
        send_event(mjs_pkg::OP_NEW, 8'd5, 16'd10, 8'd3, 3'd0);
        send_event(mjs_pkg::OP_NEW, 8'd6, 16'd1, 8'd3, 3'd0);
        send_event(mjs_pkg::OP_EXPIRE, 8'd0, 16'd0, 8'd0, 3'd1);
        send_event(mjs_pkg::OP_FINISH, 8'd0, 16'd0, 8'd0, 3'd0);
        send_event(mjs_pkg::OP_FINISH, 8'd0, 16'd0, 8'd0, 3'd5);
        send_event(OP_UNKNOWN, 8'hAA, 16'h5555, 8'h55, 3'd2);
        send_event(mjs_pkg::OP_FINISH, 8'd0, 16'd0, 8'd0, 3'd1);
        send_event(mjs_pkg::OP_FINISH, 8'd0, 16'd0, 8'd0, 3'd0);
        send_event(mjs_pkg::OP_EXPIRE, 8'd0, 16'd0, 8'd0, 3'd0);
        send_event(mjs_pkg::OP_FINISH, 8'd0, 16'd0, 8'd0, 3'd1);
        drain();

        // Queue-full corners: one core, more than 64 arrivals, then expiries and finishes.
        write_reg(mjs_pkg::CFG_NUM_CORES, 8'd1);
        write_reg(mjs_pkg::CFG_SCHEME, {5'd0, mjs_pkg::SCH_PPRI});
        for (int i = 0; i < 68; i++)
            send_event(mjs_pkg::OP_NEW, 8'(i), 16'(i), 8'(200 - i), 3'd0);
        send_event(mjs_pkg::OP_EXPIRE, 8'd0, 16'd0, 8'd0, 3'd0);
        drain();
        write_reg(mjs_pkg::CFG_SCHEME, {5'd0, mjs_pkg::SCH_RR});
        send_event(mjs_pkg::OP_EXPIRE, 8'd0, 16'd0, 8'd0, 3'd0);
        for (int i = 0; i < 66; i++)
            send_event(mjs_pkg::OP_FINISH, 8'd0, 16'd0, 8'd0, 3'd0);
        drain();

        for (int ph = 0; ph < 14; ph++)
        begin
            write_reg(mjs_pkg::CFG_SCHEME, 8'(ph < 12 ? ph % 8 : $urandom_range(0, 7)));
            write_reg(mjs_pkg::CFG_NUM_CORES, 8'(ph == 0 ? 0 : ph == 1 ? 15 : ph == 2 ? 8
                                                 : $urandom_range(0, 15)));
            calm = (ph >= 12);
            for (int i = 0; i < 100; i++) random_event((i % 40 < 25) ? 75 : 30);
            if (ph == 6) drain();
            drain();
        end

        if (board.errors == 0 && board.pending.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
